// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the echo range filter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Condition that must hold in the cycle after the trigger
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- hdl/uerf_pkg.sv -----
// Shared types and constants of the ultrasonic echo range filter
package uerf_pkg;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int TICKS_W  = 16;
    localparam int DIST_W   = 11;
    localparam int THRESH_W = 9;
    localparam int CFG_IDX_W = 2;

    // Ring depth is a power of two so the average is a plain shift
    localparam int AVG_LOG2  = 1;
    localparam int AVG_DEPTH = 1 << AVG_LOG2;
    localparam int POS_W     = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
    localparam int WARM_W    = AVG_LOG2 + 1;
    localparam int SUM_W     = DIST_W + AVG_LOG2;

    // ticks*17/1000 as a multiply by a scaled reciprocal, exact for 16-bit ticks
    localparam int DIST_SHIFT = 26;
    localparam int MUL_W      = 21;
    localparam int PROD_W     = TICKS_W + MUL_W;
    localparam logic [MUL_W-1:0] DIST_MUL = MUL_W'((17 * (64'd1 << DIST_SHIFT) + 999) / 1000);
    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(1114);

    // Operation and level codes
    localparam logic OP_ECHO    = 1'b0;
    localparam logic OP_REARM   = 1'b1;
    localparam logic LEVEL_FALL = 1'b0;
    localparam logic LEVEL_RISE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [TICKS_W-1:0]  ECHO_MIN_RST = 16'd50;
    localparam logic [TICKS_W-1:0]  ECHO_MAX_RST = 16'd30000;
    localparam logic [THRESH_W-1:0] OBSTACLE_RST = 9'd50;

    // Item handed to the averaging stage
    typedef struct packed {
        logic              rearm;
        logic [DIST_W-1:0] dist_cm;
    } uerf_sample_t;

    // Result of the averaging stage
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              alert;
    } uerf_report_t;

endpackage

// ----- hdl/uerf_meas_if.sv -----
// Measurement channel: echo edge and rearm beats
interface uerf_meas_if import uerf_pkg::*;;
    logic              valid;
    logic              ready;
    logic              operation;
    logic              echo_level;
    logic [TIME_W-1:0] time_us;

    modport source (output valid, operation, echo_level, time_us, input ready);
    modport sink   (input valid, operation, echo_level, time_us, output ready);
endinterface

// ----- hdl/uerf_result_if.sv -----
// Result channel: reported distance and alert flag
interface uerf_result_if import uerf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance_cm;
    logic              obstacle_alert;

    modport source (output valid, distance_cm, obstacle_alert, input ready);
    modport sink   (input valid, distance_cm, obstacle_alert, output ready);
endinterface

// ----- hdl/uerf_cfg_if.sv -----
// Configuration write channel
interface uerf_cfg_if import uerf_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TICKS_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/uerf_ring_avg.sv -----
// Sample ring, warmup count, moving average and alert latch
`include "assert_macros.svh"

module uerf_ring_avg import uerf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  uerf_sample_t        sample,
    input  logic [THRESH_W-1:0] threshold,
    output uerf_report_t        report
);

    logic [DIST_W-1:0] ring_reg [AVG_DEPTH];
    logic [DIST_W-1:0] ring_next [AVG_DEPTH];
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [WARM_W-1:0] warm_reg;
    logic              latched_reg;
    logic              warm_done;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  avg_wide;
    logic [DIST_W-1:0] avg;

    // ring with the new sample written in
    always_comb
    begin
        for (int i = 0; i < AVG_DEPTH; i++)
        begin
            ring_next[i] = (pos_reg == POS_W'(i)) ? sample.dist_cm : ring_reg[i];
        end
    end

    // sum and average over the updated ring
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < AVG_DEPTH; i++)
        begin
            sum = sum + SUM_W'(ring_next[i]);
        end
        avg_wide = sum >> AVG_LOG2;
        avg      = avg_wide[DIST_W-1:0];
    end

    assign pos_next  = (pos_reg == POS_W'(AVG_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
    assign warm_done = (warm_reg == WARM_W'(AVG_DEPTH));

    // raw distance during warmup, average afterwards
    assign report.distance = warm_done ? avg : sample.dist_cm;
    assign report.alert    = !sample.rearm && warm_done && !latched_reg
                             && (avg < DIST_W'(threshold));

    // state update, one beat per take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AVG_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg     <= '0;
            warm_reg    <= '0;
            latched_reg <= 1'b0;
        end
        else if (take)
        begin
            if (sample.rearm)
            begin
                latched_reg <= 1'b0;
            end
            else
            begin
                ring_reg <= ring_next;
                pos_reg  <= pos_next;
                if (!warm_done)
                begin
                    warm_reg <= warm_reg + 1'b1;
                end
                if (report.alert)
                begin
                    latched_reg <= 1'b1;
                end
            end
        end
    end

    `ASSERT_IMPL(a_warm_bound, 1'b1, warm_reg <= WARM_W'(AVG_DEPTH), "warmup count overrun")
    `ASSERT_NEXT(a_alert_latches, take && report.alert, latched_reg, "alert not latched")
    `ASSERT_IMPL(a_alert_after_warmup, take && report.alert, warm_done, "alert during warmup")

endmodule

// ----- hdl/ultrasonic_echo_range_filter.sv -----
// Ultrasonic echo range filter: pulse timing, range check, distance and moving average
// Throughput: one beat per cycle unless result.ready stalls; beats pass four register
// stages (input, pulse, distance, result) each handing on independently, so a new beat
// is taken while a result waits. Only in-range falling-edge beats yield a result beat.
// Reset (rst_n, asynchronous, active low) clears pipeline valids, rise time, ring,
// warmup count and alert latch, and loads the configuration reset values.
`include "assert_macros.svh"

module ultrasonic_echo_range_filter import uerf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    uerf_meas_if.sink    meas,
    uerf_result_if.source result,
    uerf_cfg_if.sink     cfg
);

    // configuration
    logic [TICKS_W-1:0]  echo_min_reg;
    logic [TICKS_W-1:0]  echo_max_reg;
    logic [THRESH_W-1:0] obstacle_reg;

    // input stage
    logic              a_valid_reg;
    logic              a_op_reg;
    logic              a_level_reg;
    logic [TIME_W-1:0] a_time_reg;
    logic [TIME_W-1:0] rise_time_reg;
    logic [TIME_W-1:0] ticks;
    logic              in_range;
    logic              a_pass;
    logic              a_go;
    logic              meas_take;

    // pulse stage
    logic               b_valid_reg;
    logic               b_rearm_reg;
    logic [TICKS_W-1:0] b_ticks_reg;
    logic [PROD_W-1:0]  prod;
    logic               b_go;

    // distance stage
    logic         c_valid_reg;
    uerf_sample_t c_sample_reg;
    logic         c_go;
    uerf_report_t report;

    // result register
    logic              out_valid_reg;
    logic [DIST_W-1:0] distance_reg;
    logic              alert_reg;

    // configuration writes, always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_min_reg <= ECHO_MIN_RST;
            echo_max_reg <= ECHO_MAX_RST;
            obstacle_reg <= OBSTACLE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ECHO_MIN: echo_min_reg <= cfg.data;
                REG_ECHO_MAX: echo_max_reg <= cfg.data;
                REG_OBSTACLE: obstacle_reg <= cfg.data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // pulse width and range check
    assign ticks    = a_time_reg - rise_time_reg;
    assign in_range = (ticks[TIME_W-1:TICKS_W] == '0)
                      && (ticks[TICKS_W-1:0] >= echo_min_reg)
                      && (ticks[TICKS_W-1:0] <= echo_max_reg);
    assign a_pass   = (a_op_reg == OP_REARM) || ((a_level_reg == LEVEL_FALL) && in_range);

    // stage handover
    assign c_go = c_valid_reg && (c_sample_reg.rearm || !out_valid_reg || result.ready);
    assign b_go = b_valid_reg && (!c_valid_reg || c_go);
    assign a_go = a_valid_reg && (!a_pass || !b_valid_reg || b_go);

    assign meas.ready = !a_valid_reg || a_go;
    assign meas_take  = meas.valid && meas.ready;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            rise_time_reg <= '0;
        end
        else
        begin
            if (meas_take)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_go)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_go && (a_op_reg == OP_ECHO) && (a_level_reg == LEVEL_RISE))
            begin
                rise_time_reg <= a_time_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (meas_take)
        begin
            a_op_reg    <= meas.operation;
            a_level_reg <= meas.echo_level;
            a_time_reg  <= meas.time_us;
        end
    end

    // pulse stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (a_go && a_pass)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (b_go)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_go && a_pass)
        begin
            b_rearm_reg <= (a_op_reg == OP_REARM);
            b_ticks_reg <= ticks[TICKS_W-1:0];
        end
    end

    // distance in cm by reciprocal multiply
    assign prod = PROD_W'(b_ticks_reg) * PROD_W'(DIST_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (b_go)
        begin
            c_valid_reg <= 1'b1;
        end
        else if (c_go)
        begin
            c_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            c_sample_reg.rearm   <= b_rearm_reg;
            c_sample_reg.dist_cm <= prod[DIST_SHIFT +: DIST_W];
        end
    end

    // ring, average and alert latch
    uerf_ring_avg u_ring_avg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (c_go),
        .sample    (c_sample_reg),
        .threshold (obstacle_reg),
        .report    (report)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (c_go && !c_sample_reg.rearm)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_go && !c_sample_reg.rearm)
        begin
            distance_reg <= report.distance;
            alert_reg    <= report.alert;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.distance_cm    = distance_reg;
    assign result.obstacle_alert = alert_reg;

    `ASSERT_IMPL(a_dist_bound, out_valid_reg, distance_reg <= DIST_MAX, "distance out of range")

endmodule
